// ===== src/spu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spu_pkg: shared types and constants of the softmax probability unit
// Holds widths, the exp table function and the sequencer state type.
// ----------------------------------------------------------------------------
package spu_pkg;

    localparam int MaxActions   = 64;
    localparam int ExpEntries   = 256;
    localparam int AddrW        = $clog2(MaxActions);
    localparam int CountW       = $clog2(MaxActions + 1);
    localparam int ExpIdxW      = $clog2(ExpEntries);
    localparam int ScoreW       = 16;
    localparam int GainW        = 16;
    localparam int WeightW      = 17;
    localparam int SumW         = 23;
    localparam int ProbW        = 17;
    localparam int IndexW       = 6;
    localparam logic [30:0] Log2eQ30 = 31'd1549082005;
    localparam logic [GainW-1:0] GainReset = 16'd4096;
    localparam real InvEntries  = 1.0 / ExpEntries;

    typedef enum logic [2:0] {
        t_st_load,
        t_st_wread,
        t_st_wcalc,
        t_st_wtab,
        t_st_wsum,
        t_st_dread,
        t_st_div,
        t_st_emit
    } t_state;

    typedef struct packed {
        logic [ScoreW-1:0] score;
        logic              last_score;
    } t_in_req;

    typedef struct packed {
        logic [ProbW-1:0]  probability;
        logic [IndexW-1:0] action_index;
        logic              last_probability;
    } t_out_req;

    // round(65536 * 2^(-f/ExpEntries)), evaluated at elaboration
    function automatic logic [WeightW-1:0] exp_entry(input int unsigned f);
        exp_entry = WeightW'($rtoi(65536.0 * 2.0 ** (0.0 - real'(f) * InvEntries) + 0.5));
    endfunction

endpackage

// ===== src/spu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spu_in_if / spu_out_if: valid-ready channels of the softmax unit
// Carry one score request in and one probability request out.
// ----------------------------------------------------------------------------
interface spu_in_if;
    logic                           valid;
    logic                           ready;
    logic [spu_pkg::ScoreW-1:0]     score;
    logic                           last_score;
    modport source (output valid, output score, output last_score, input ready);
    modport sink (input valid, input score, input last_score, output ready);
endinterface

interface spu_out_if;
    logic                           valid;
    logic                           ready;
    logic [spu_pkg::ProbW-1:0]      probability;
    logic [spu_pkg::IndexW-1:0]     action_index;
    logic                           last_probability;
    modport source (output valid, output probability, output action_index,
                    output last_probability, input ready);
    modport sink (input valid, input probability, input action_index,
                  input last_probability, output ready);
endinterface

// ===== src/spu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spu_ram: generic single-port RAM with registered read
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module spu_ram #(
    parameter int Width = 16,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== src/softmax_probability_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_probability_unit_core: fixed-point softmax over one set of scores
// Stores scores, computes exp weights, then divides each by their sum.
// ----------------------------------------------------------------------------
// Scores load at one request per cycle into a score RAM while the running
// maximum is tracked; the request that carries last_score closes the set
// (scores beyond 64 are dropped but their last mark still closes). The block
// then takes no request until every probability is out. Weight pass, per
// action: score RAM read, lambda product, log2(e) product and rounding,
// table shift with weight RAM write and sum accumulation. Divide pass, per
// action: weight RAM read, divider load, a restoring divider with 17
// quotient steps, output, which waits while the output stalls. The divider
// sets the sustained rate.
// ----------------------------------------------------------------------------
module softmax_probability_unit_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [spu_pkg::GainW-1:0]  i_cfg_wdata,
    spu_in_if.sink                     i_in,
    spu_out_if.source                  o_out
);
    import spu_pkg::*;

    t_state r_state, n_state;
    logic [GainW-1:0]   r_gain;
    logic [ScoreW-1:0]  r_max, n_max;
    logic [CountW-1:0]  r_count, n_count;
    logic [CountW-1:0]  r_idx, n_idx;
    logic [SumW-1:0]    r_sum, n_sum;
    logic [31:0]        r_d, n_d;
    logic [19:0]        r_u, n_u;
    logic [WeightW+16-1:0] r_num, n_num;
    logic [SumW:0]      r_rem, n_rem;
    logic [ProbW-1:0]   r_quo, n_quo;
    logic [4:0]         r_bit, n_bit;
    t_out_req           r_out, n_out;
    logic               r_ovalid, n_ovalid;

    logic               s_we, w_we;
    logic [AddrW-1:0]   s_addr, w_addr;
    logic [ScoreW-1:0]  s_rdata;
    logic [WeightW-1:0] w_wdata, w_rdata;
    logic [WeightW-1:0] exp_tab [ExpEntries];

    for (genvar f = 0; f < ExpEntries; f++) begin : g_tab
        assign exp_tab[f] = exp_entry(f);
    end

    spu_ram #(.Width(ScoreW), .Depth(MaxActions)) u_score_ram (
        .i_clk, .i_we(s_we), .i_addr(s_addr), .i_wdata(i_in.score), .o_rdata(s_rdata)
    );
    spu_ram #(.Width(WeightW), .Depth(MaxActions)) u_weight_ram (
        .i_clk, .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wdata), .o_rdata(w_rdata)
    );

    logic in_fire;
    logic [ScoreW-1:0] diff;
    logic [62:0] prod;
    logic [ExpIdxW-1:0] tab_idx;
    logic [WeightW-1:0] weight;
    logic [SumW:0] trial;

    assign i_in.ready = (r_state == t_st_load);
    assign in_fire    = i_in.valid && i_in.ready;
    assign o_out.valid = r_ovalid;
    assign o_out.probability = r_out.probability;
    assign o_out.action_index = r_out.action_index;
    assign o_out.last_probability = r_out.last_probability;

    assign diff    = r_max - s_rdata;
    assign prod    = 63'(r_d) * 63'(Log2eQ30);
    assign tab_idx = ExpIdxW'((32'(r_u[7:0]) * ExpEntries) >> 8);
    assign weight  = (r_u[19:8] > 12'd16) ? '0 : (exp_tab[tab_idx] >> r_u[19:8]);
    assign trial   = {r_rem[SumW-1:0], r_num[WeightW+16-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= t_st_load;
            r_gain   <= GainReset;
            r_max    <= {1'b1, {(ScoreW-1){1'b0}}};
            r_count  <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) r_gain <= i_cfg_wdata;
            r_max    <= n_max;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_ovalid <= n_ovalid;
        end
        r_idx <= n_idx;
        r_d   <= n_d;
        r_u   <= n_u;
        r_num <= n_num;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_bit <= n_bit;
        r_out <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_max = r_max; n_count = r_count; n_idx = r_idx; n_sum = r_sum;
        n_d = r_d; n_u = r_u; n_num = r_num; n_rem = r_rem; n_quo = r_quo;
        n_bit = r_bit; n_out = r_out; n_ovalid = r_ovalid;
        s_we = 1'b0; s_addr = AddrW'(r_idx);
        w_we = 1'b0; w_addr = AddrW'(r_idx); w_wdata = weight;
        if (o_out.ready) n_ovalid = 1'b0;
        case (r_state)
            t_st_load: begin
                s_addr = AddrW'(r_count);
                if (in_fire) begin
                    // store while room remains, drop overflow
                    if (r_count < CountW'(MaxActions)) begin
                        s_we = 1'b1;
                        n_count = r_count + CountW'(1);
                        if ($signed(i_in.score) > $signed(r_max)) n_max = i_in.score;
                    end
                    if (i_in.last_score) begin
                        n_idx = '0; n_sum = '0;
                        n_state = t_st_wread;
                    end
                end
            end
            t_st_wread: n_state = t_st_wcalc;
            t_st_wcalc: begin
                n_d = 32'(r_gain) * 32'(diff);
                n_state = t_st_wtab;
            end
            t_st_wtab: begin
                // u = round(d * log2e) at 8 fraction bits, saturate huge
                n_u = (prod[62:42] + 21'(prod[41]) > 21'hFFFFF) ? 20'hFFFFF
                      : 20'(prod[62:42] + 21'(prod[41]));
                n_state = t_st_wsum;
            end
            t_st_wsum: begin
                // commit the weight and add it to the sum
                w_we = 1'b1;
                n_sum = r_sum + SumW'(weight);
                if (r_idx + CountW'(1) == r_count) begin
                    n_idx = '0;
                    n_state = t_st_dread;
                end else begin
                    n_idx = r_idx + CountW'(1);
                    n_state = t_st_wread;
                end
            end
            t_st_dread: begin
                n_bit = 5'd0;
                n_state = t_st_div;
            end
            t_st_div: begin
                if (r_bit == 5'd0) begin
                    // weight <= sum, so the upper 16 quotient bits are zero:
                    // start with the weight's top bits as the remainder
                    n_num = {w_rdata[0], 32'd0};
                    n_rem = (SumW+1)'(w_rdata[WeightW-1:1]);
                    n_quo = '0;
                    n_bit = 5'd1;
                end else begin
                    if (trial >= {1'b0, r_sum}) begin
                        n_rem = trial - {1'b0, r_sum};
                        n_quo = {r_quo[ProbW-2:0], 1'b1};
                    end else begin
                        n_rem = trial;
                        n_quo = {r_quo[ProbW-2:0], 1'b0};
                    end
                    n_num = r_num << 1;
                    n_bit = r_bit + 5'd1;
                    if (r_bit == 5'(ProbW)) n_state = t_st_emit;
                end
            end
            t_st_emit: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_out.probability = r_quo;
                    n_out.action_index = IndexW'(r_idx);
                    n_out.last_probability = (r_idx + CountW'(1) == r_count);
                    if (r_idx + CountW'(1) == r_count) begin
                        n_count = '0; n_sum = '0;
                        n_max = {1'b1, {(ScoreW-1){1'b0}}};
                        n_state = t_st_load;
                    end else begin
                        n_idx = r_idx + CountW'(1);
                        n_state = t_st_dread;
                    end
                end
            end
            default: n_state = t_st_load;
        endcase
    end
endmodule

// ===== tb/softmax_probability_unit_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_probability_unit_core_test: self-checking bench of the softmax unit
// Feeds score sets through the request channel, predicts every probability
// with a fixed-point softmax model kept here, and checks each output request
// in order. A directed table comes first, then random sets at several gains.
// ----------------------------------------------------------------------------
module softmax_probability_unit_core_test;
    import spu_pkg::*;

    // One row of the directed table. pin_prob < 0 means "use the predictor".
    typedef struct {
        logic [ScoreW-1:0] score;
        logic              last_score;
        int                pin_prob;
    } t_row;

    typedef struct {
        logic [ProbW-1:0]  probability;
        logic [IndexW-1:0] action_index;
        logic              last_probability;
    } t_prob_exp;

    localparam int NRows = 20;
    localparam int NoPin = -1;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [GainW-1:0]  i_cfg_wdata = '0;
    logic              out_pace = 1'b1;   // 0: hold ready high, no stalls

    spu_in_if  in_ch ();
    spu_out_if out_ch ();

    softmax_probability_unit_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Model state: the open set, the gain and the exp lookup.
    logic [WeightW-1:0]       exp_lut [ExpEntries];
    logic signed [ScoreW-1:0] set_scores [MaxActions];
    int                       set_pins [MaxActions];
    int                       set_count;
    logic signed [ScoreW-1:0] set_max;
    logic [GainW-1:0]         gain;
    t_prob_exp                prob_queue [$];
    int                       errors = 0;
    int                       items_sent = 0;
    t_row                     rows [NRows];

    // Exp weight of one score against the set maximum.
    function automatic logic [WeightW-1:0] exp_weight(logic signed [ScoreW-1:0] s);
        longint unsigned diff;
        longint unsigned d;
        longint unsigned u;
        longint unsigned ip;
        diff = longint'(set_max) - longint'(s);
        d    = longint'(gain) * diff;
        u    = (d * 64'd1549082005 + (64'd1 << 41)) >> 42;
        ip   = u >> 8;
        if (ip > 16)
            return '0;
        return exp_lut[u & 64'hFF] >> ip;
    endfunction

    // Take one accepted score; on the closing score queue the set's probabilities.
    task automatic take_score(logic [ScoreW-1:0] raw, logic last, int pin);
        logic [WeightW-1:0] w [MaxActions];
        longint unsigned    wsum;
        t_prob_exp          e;
        if (set_count < MaxActions) begin
            set_scores[set_count] = raw;
            set_pins[set_count]   = pin;
            if ($signed(raw) > set_max)
                set_max = raw;
            set_count++;
        end
        if (!last)
            return;
        wsum = 0;
        for (int i = 0; i < set_count; i++) begin
            w[i] = exp_weight(set_scores[i]);
            wsum += w[i];
        end
        for (int i = 0; i < set_count; i++) begin
            e.probability = (wsum == 0) ? '0 : ProbW'((longint'(w[i]) << 16) / wsum);
            if (set_pins[i] >= 0)
                e.probability = ProbW'(set_pins[i]);
            e.action_index     = IndexW'(i);
            e.last_probability = (i + 1 == set_count);
            prob_queue.push_back(e);
        end
        set_count = 0;
        set_max   = 16'sh8000;
    endtask

    // Present one score request, after a random gap when paced, and hold it until accepted.
    task automatic send_score(logic [ScoreW-1:0] raw, logic last, int pin, bit pace);
        int gap;
        gap = pace ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.score      <= raw;
        in_ch.last_score <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        take_score(raw, last, pin);
        items_sent++;
    endtask

    // Let the block drain, then write the gain.
    task automatic write_gain(logic [GainW-1:0] value);
        in_ch.valid <= 1'b0;
        wait (prob_queue.size() == 0);
        repeat (40) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gain = value;
    endtask

    // Random set: mostly short, sometimes long, rarely past capacity.
    task automatic send_random_set(int len, bit pace);
        logic [ScoreW-1:0] base;
        logic [ScoreW-1:0] s;
        base = ScoreW'($urandom);
        for (int i = 0; i < len; i++) begin
            // cluster most scores near a base so weights stay nonzero
            if ($urandom_range(0, 3) == 0)
                s = ScoreW'($urandom);
            else
                s = base + ScoreW'($urandom_range(0, 1023)) - 16'd512;
            send_score(s, i == len - 1, NoPin, pace);
        end
    endtask

    initial begin
        for (int f = 0; f < ExpEntries; f++)
            exp_lut[f] = WeightW'($rtoi(65536.0 * 2.0 ** (-real'(f) / 256.0) + 0.5));
        set_count = 0;
        set_max   = 16'sh8000;
        gain      = GainReset;
    end

    // Directed table: single sets, extremes and ties at the reset gain.
    initial begin
        rows = '{
            '{16'd100,    1'b1, 65536},   // lone action takes all
            '{16'h8000,   1'b0, 0},       // full range: bottom weighs nothing
            '{16'h7FFF,   1'b1, 65536},
            '{16'd5,      1'b0, 32768},   // tie splits evenly
            '{16'd5,      1'b1, 32768},
            '{16'h8000,   1'b1, 65536},   // most negative score alone
            '{16'h7FFF,   1'b1, 65536},
            '{16'd0,      1'b0, NoPin},
            '{16'd256,    1'b0, NoPin},
            '{16'hFF00,   1'b0, NoPin},
            '{16'd1000,   1'b1, NoPin},
            '{16'h0001,   1'b0, NoPin},
            '{16'hFFFF,   1'b0, NoPin},
            '{16'h0000,   1'b0, NoPin},
            '{16'h0002,   1'b1, NoPin},
            '{16'h5555,   1'b0, NoPin},
            '{16'hAAAA,   1'b0, NoPin},
            '{16'h5500,   1'b1, NoPin},
            '{16'h0040,   1'b0, NoPin},
            '{16'h0000,   1'b1, NoPin}
        };
    end

    // Request side: reset, directed table, then random phases at several gains.
    initial begin
        logic [GainW-1:0] gains [8];
        in_ch.valid      <= 1'b0;
        in_ch.score      <= '0;
        in_ch.last_score <= 1'b0;
        gains = '{16'd0, 16'hFFFF, 16'd4096, 16'd1, 16'd0, 16'd8192, 16'hFFFF, 16'd4096};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NRows; r++)
            send_score(rows[r].score, rows[r].last_score, rows[r].pin_prob, 1'b1);

        for (int p = 0; p < 8; p++) begin
            bit pace;
            write_gain(p == 7 ? GainW'($urandom) : gains[p]);
            pace     = (p % 3 != 2);
            out_pace <= pace;
            // at gain zero all scores weigh the same and pin the split; check one directly
            if (p == 0) begin
                send_score(16'h1234, 1'b0, 32768, 1'b1);
                send_score(16'h8000, 1'b1, 32768, 1'b1);
            end
            // overflow: drop scores past capacity, last still closes
            if (p == 2 || p == 6)
                send_random_set(MaxActions + 6, pace);
            while (items_sent < 20 + 50 * (p + 1)) begin
                if ($urandom_range(0, 9) == 0)
                    send_random_set($urandom_range(20, MaxActions), pace);
                else
                    send_random_set($urandom_range(1, 8), pace);
            end
        end
        in_ch.valid <= 1'b0;

        wait (prob_queue.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Output side: stall ready at random, check each accepted request.
    initial begin
        int stall;
        t_prob_exp e;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = out_pace ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            if (prob_queue.size() == 0) begin
                $display("%0t: unexpected output request prob=%0d idx=%0d last=%0b",
                         $time, out_ch.probability, out_ch.action_index,
                         out_ch.last_probability);
                errors++;
            end else begin
                e = prob_queue.pop_front();
                if (out_ch.probability !== e.probability) begin
                    $display("%0t: probability expected %0d actual %0d", $time,
                             e.probability, out_ch.probability);
                    errors++;
                end
                if (out_ch.action_index !== e.action_index) begin
                    $display("%0t: action_index expected %0d actual %0d", $time,
                             e.action_index, out_ch.action_index);
                    errors++;
                end
                if (out_ch.last_probability !== e.last_probability) begin
                    $display("%0t: last_probability expected %0b actual %0b", $time,
                             e.last_probability, out_ch.last_probability);
                    errors++;
                end
            end
        end
    end

    // Watchdog: far above the slowest correct run.
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
